[hdl/turtle_melody_interpreter_assert.svh]
// assertion macros for the turtle melody interpreter checker
// no dependencies; included by tmi_checker.sv
`ifndef TURTLE_MELODY_INTERPRETER_ASSERT_SVH
`define TURTLE_MELODY_INTERPRETER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TMI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tmi_pkg.sv]
// shared constants, types and helper functions for the turtle melody interpreter
// no dependencies; imported by every module of the block
package tmi_pkg;

  localparam int LADDER_SIZE = 128;
  localparam int STACK_DEPTH = 64;
  localparam int MAX_NOTES   = 512;
  localparam int MAX_STEPS   = 4096;

  localparam int LEN_W  = 8;
  localparam int POS_W  = 7;
  localparam int NOTE_W = 7;
  localparam int OCT_W  = 14;
  localparam int ACC_W  = 14;
  localparam int EVI_W  = 9;
  localparam int STO_W  = 13;
  localparam int ST_W   = $clog2(MAX_STEPS + 1);
  localparam int NC_W   = $clog2(MAX_NOTES + 1);
  localparam int SC_W   = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int MIX_W  = 19;

  localparam logic signed [OCT_W-1:0] OCT_MAX = 14'sd8191;
  localparam logic signed [OCT_W-1:0] OCT_MIN = -14'sd8192;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 14'sd4096;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -14'sd4096;
  localparam logic signed [MIX_W-1:0] MIDI_MAX = 19'sd127;
  localparam logic signed [MIX_W-1:0] OCT_SEMIS = 19'sd12;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SYMBOL = 2'd1;
  localparam logic [1:0] REQ_PHRASE = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_NOTE = 2'd1;
  localparam logic [1:0] EV_TIE  = 2'd2;

  localparam logic [7:0] SYM_NOTE   = 8'h46;
  localparam logic [7:0] SYM_REST   = 8'h72;
  localparam logic [7:0] SYM_TIE    = 8'h5F;
  localparam logic [7:0] SYM_UP     = 8'h2B;
  localparam logic [7:0] SYM_DOWN   = 8'h2D;
  localparam logic [7:0] SYM_PUSH   = 8'h5B;
  localparam logic [7:0] SYM_POP    = 8'h5D;
  localparam logic [7:0] SYM_ACC_UP = 8'h3E;
  localparam logic [7:0] SYM_ACC_DN = 8'h3C;

  typedef struct packed {
    logic [ST_W-1:0]         step;
    logic [POS_W-1:0]        pos;
    logic signed [OCT_W-1:0] oct;
  } stk_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  widx;
    logic [NOTE_W-1:0] wnote;
    logic [POS_W-1:0]  raddr;
  } lad_ctrl_t;

  function automatic logic [NOTE_W-1:0] ladder_init(input logic [POS_W-1:0] idx);
    logic [NOTE_W-1:0] n;
    case (idx)
      7'd0:    n = 7'd48;
      7'd1:    n = 7'd50;
      7'd2:    n = 7'd52;
      7'd3:    n = 7'd55;
      7'd4:    n = 7'd57;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] len_in_use(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(LADDER_SIZE)) ? LEN_W'(LADDER_SIZE) : len;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] pos,
                                                 input logic [LEN_W-1:0] len);
    logic [POS_W-1:0] p;
    p = pos;
    if (len != '0 && LEN_W'(pos) >= len) begin
      p = POS_W'(len - LEN_W'(1));
    end
    return p;
  endfunction

endpackage

[hdl/turtle_melody_interpreter.sv]
// turtle melody interpreter top level: input register, turtle state update,
// result register; depends on tmi_pkg, tmi_ladder and tmi_stack
//
//   channel  direction  tdata fields (low bit up)                   tuser
//   in_      slave      ladder_index, ladder_note, symbol           req_type
//   out_     master     event_index, start_step, midi_note,
//                       accent_marks, phrase_length, stack_overflow event_kind
//   cfg_     write      ladder_length                               -
//
// one word per cycle sustained while out_tready is high; a word is held in the input
// register and leaves through the result register
// ladder and stack reads are prefetched into their read registers
// reset clears all turtle state and restores the default ladder at once
// a stalled result holds; the input register takes one more word, then in_tready drops
module turtle_melody_interpreter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // ladder_index, ladder_note, symbol
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // event_index, start_step, midi_note, accent_marks,
                                  // phrase_length, stack_overflow
  output logic [1:0]  out_tuser,  // event_kind
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata   // ladder_length
);
  import tmi_pkg::*;

  logic              in_valid_r;
  logic [1:0]        req_r;
  logic [POS_W-1:0]  lidx_r;
  logic [NOTE_W-1:0] lnote_r;
  logic [7:0]        sym_r;
  logic              go;

  logic [LEN_W-1:0]        len_r;
  logic [ST_W-1:0]         step_r, step_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [OCT_W-1:0] oct_r, oct_nxt;
  logic                    tie_v_r, tie_v_nxt;
  logic [EVI_W-1:0]        tie_r, tie_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [NC_W-1:0]         ncnt_r, ncnt_nxt;
  logic [ST_W-1:0]         longest_r, longest_nxt;

  logic [LEN_W-1:0]        len_use;
  logic [LEN_W-1:0]        len_next_use;
  logic [POS_W-1:0]        p;
  logic [ST_W-1:0]         step_adv;
  logic signed [MIX_W-1:0] note_m;

  lad_ctrl_t         lad_ctrl;
  logic [NOTE_W-1:0] lad_note;
  stk_ctrl_t         stk_ctrl;
  stk_entry_t        stk_push;
  stk_entry_t        stk_top;
  logic [SC_W-1:0]   stk_count;

  logic              out_valid_r;
  logic [1:0]        kind_r, kind_nxt;
  logic [EVI_W-1:0]  evi_r, evi_nxt;
  logic [STO_W-1:0]  start_r, start_nxt;
  logic [NOTE_W-1:0] midi_r, midi_nxt;
  logic [ACC_W-1:0]  acco_r, acco_nxt;
  logic [STO_W-1:0]  plen_r, plen_nxt;
  logic              ovf_r, ovf_nxt;

  // input register
  assign go        = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r   <= in_tuser;
      lidx_r  <= in_tdata[6:0];
      lnote_r <= in_tdata[13:7];
      sym_r   <= in_tdata[21:14];
    end
  end

  // ladder length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(5);
    end else if (cfg_we) begin
      len_r <= cfg_wdata;
    end
  end

  assign len_use      = len_in_use(len_r);
  assign len_next_use = len_in_use(cfg_we ? cfg_wdata : len_r);
  assign p            = clamp_pos(pos_r, len_use);
  assign step_adv     = (step_r < ST_W'(MAX_STEPS)) ? step_r + ST_W'(1) : step_r;
  assign note_m       = MIX_W'($signed({1'b0, lad_note})) + MIX_W'(oct_r) * OCT_SEMIS;
  assign stk_push     = '{step: step_r, pos: pos_r, oct: oct_r};

  always_comb begin
    step_nxt    = step_r;
    pos_nxt     = pos_r;
    oct_nxt     = oct_r;
    tie_v_nxt   = tie_v_r;
    tie_nxt     = tie_r;
    acc_nxt     = acc_r;
    ncnt_nxt    = ncnt_r;
    longest_nxt = longest_r;
    kind_nxt    = EV_NONE;
    evi_nxt     = '0;
    start_nxt   = '0;
    midi_nxt    = '0;
    acco_nxt    = '0;
    ovf_nxt     = 1'b0;
    stk_ctrl    = '0;
    lad_ctrl.we    = 1'b0;
    lad_ctrl.widx  = lidx_r;
    lad_ctrl.wnote = lnote_r;
    if (go) begin
      case (req_r)
        REQ_LOAD: begin
          lad_ctrl.we = (32'(lidx_r) < LADDER_SIZE);
        end
        REQ_PHRASE: begin
          step_nxt       = '0;
          pos_nxt        = '0;
          oct_nxt        = '0;
          tie_v_nxt      = 1'b0;
          tie_nxt        = '0;
          acc_nxt        = '0;
          ncnt_nxt       = '0;
          longest_nxt    = '0;
          stk_ctrl.clear = 1'b1;
        end
        REQ_SYMBOL: begin
          case (sym_r)
            SYM_NOTE: begin
              tie_v_nxt = 1'b0;
              if (len_use != '0 && !note_m[MIX_W-1] && note_m <= MIDI_MAX &&
                  ncnt_r < NC_W'(MAX_NOTES)) begin
                kind_nxt  = EV_NOTE;
                evi_nxt   = EVI_W'(ncnt_r);
                start_nxt = STO_W'(step_r);
                midi_nxt  = NOTE_W'(note_m);
                acco_nxt  = acc_r;
                tie_nxt   = EVI_W'(ncnt_r);
                tie_v_nxt = 1'b1;
                ncnt_nxt  = ncnt_r + NC_W'(1);
              end
              acc_nxt  = '0;
              step_nxt = step_adv;
            end
            SYM_REST: begin
              tie_v_nxt = 1'b0;
              step_nxt  = step_adv;
            end
            SYM_TIE: begin
              if (tie_v_r) begin
                kind_nxt = EV_TIE;
                evi_nxt  = tie_r;
              end
              step_nxt = step_adv;
            end
            SYM_ACC_UP: begin
              if (acc_r < ACC_MAX) acc_nxt = acc_r + ACC_W'(1);
            end
            SYM_ACC_DN: begin
              if (acc_r > ACC_MIN) acc_nxt = acc_r - ACC_W'(1);
            end
            SYM_UP: begin
              if (len_use != '0) begin
                if (LEN_W'(p) + LEN_W'(1) < len_use) begin
                  pos_nxt = p + POS_W'(1);
                end else if (oct_r < OCT_MAX) begin
                  pos_nxt = '0;
                  oct_nxt = oct_r + OCT_W'(1);
                end else begin
                  pos_nxt = p;
                end
              end
            end
            SYM_DOWN: begin
              if (len_use != '0) begin
                if (p != '0) begin
                  pos_nxt = p - POS_W'(1);
                end else if (oct_r > OCT_MIN) begin
                  pos_nxt = POS_W'(len_use - LEN_W'(1));
                  oct_nxt = oct_r - OCT_W'(1);
                end else begin
                  pos_nxt = p;
                end
              end
            end
            SYM_PUSH: begin
              tie_v_nxt = 1'b0;
              if (stk_count < SC_W'(STACK_DEPTH)) begin
                stk_ctrl.push = 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            SYM_POP: begin
              tie_v_nxt = 1'b0;
              if (stk_count != '0) begin
                stk_ctrl.pop = 1'b1;
                step_nxt     = stk_top.step;
                pos_nxt      = stk_top.pos;
                oct_nxt      = stk_top.oct;
              end
            end
            default: begin
            end
          endcase
          if (step_nxt > longest_r) longest_nxt = step_nxt;
        end
        default: begin
        end
      endcase
    end
    plen_nxt       = STO_W'(longest_nxt);
    lad_ctrl.raddr = clamp_pos(pos_nxt, len_next_use);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      pos_r     <= '0;
      oct_r     <= '0;
      tie_v_r   <= 1'b0;
      tie_r     <= '0;
      acc_r     <= '0;
      ncnt_r    <= '0;
      longest_r <= '0;
    end else begin
      step_r    <= step_nxt;
      pos_r     <= pos_nxt;
      oct_r     <= oct_nxt;
      tie_v_r   <= tie_v_nxt;
      tie_r     <= tie_nxt;
      acc_r     <= acc_nxt;
      ncnt_r    <= ncnt_nxt;
      longest_r <= longest_nxt;
    end
  end

  tmi_ladder u_ladder (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lad_ctrl),
    .rd_note (lad_note)
  );

  tmi_stack u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_data (stk_push),
    .count     (stk_count),
    .top       (stk_top)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kind_r  <= kind_nxt;
      evi_r   <= evi_nxt;
      start_r <= start_nxt;
      midi_r  <= midi_nxt;
      acco_r  <= acco_nxt;
      plen_r  <= plen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'b0, ovf_r, plen_r, acco_r, midi_r, start_r, evi_r};

endmodule

[hdl/tmi_ladder.sv]
// ladder note memory with reset-value valid bits and a registered read port
// depends on tmi_pkg
module tmi_ladder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tmi_pkg::lad_ctrl_t        ctrl,
  output logic [tmi_pkg::NOTE_W-1:0] rd_note
);
  import tmi_pkg::*;

  logic [NOTE_W-1:0]      mem [LADDER_SIZE];
  logic [LADDER_SIZE-1:0] vld_r;
  logic [NOTE_W-1:0]      rd_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.widx] <= ctrl.wnote;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.we) begin
      vld_r[ctrl.widx] <= 1'b1;
    end
  end

  // write-through on a load to the address being fetched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= ladder_init('0);
    end else if (ctrl.we && ctrl.widx == ctrl.raddr) begin
      rd_r <= ctrl.wnote;
    end else if (vld_r[ctrl.raddr]) begin
      rd_r <= mem[ctrl.raddr];
    end else begin
      rd_r <= ladder_init(ctrl.raddr);
    end
  end

  assign rd_note = rd_r;

endmodule

[hdl/tmi_stack.sv]
// branch stack: memory plus registered top and next-below entries
// depends on tmi_pkg
module tmi_stack (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tmi_pkg::stk_ctrl_t       ctrl,
  input  tmi_pkg::stk_entry_t      push_data,
  output logic [tmi_pkg::SC_W-1:0] count,
  output tmi_pkg::stk_entry_t      top
);
  import tmi_pkg::*;

  stk_entry_t         mem [STACK_DEPTH];
  logic [SC_W-1:0]    count_r;
  stk_entry_t         top_r;
  stk_entry_t         below_r;
  logic [STK_AW-1:0]  rd_addr;

  // entry that becomes next-below after a pop
  assign rd_addr = STK_AW'(count_r - SC_W'(3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.clear) begin
      count_r <= '0;
    end else if (ctrl.push) begin
      count_r <= count_r + SC_W'(1);
    end else if (ctrl.pop) begin
      count_r <= count_r - SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count_r[STK_AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      top_r   <= push_data;
      below_r <= top_r;
    end else if (ctrl.pop) begin
      top_r   <= below_r;
      below_r <= mem[rd_addr];
    end
  end

  assign count = count_r;
  assign top   = top_r;

endmodule

[hdl/tmi_checker.sv]
// port-level checker for the turtle melody interpreter, bound to the top level
// depends on tmi_pkg and turtle_melody_interpreter_assert.svh
`include "turtle_melody_interpreter_assert.svh"

module tmi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import tmi_pkg::*;

  `TMI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled word changed")
  `TMI_ASSERT_NOW(a_kind_legal, out_tvalid,
    out_tuser == EV_NONE || out_tuser == EV_NOTE || out_tuser == EV_TIE, "bad event kind")
  `TMI_ASSERT_NOW(a_none_zero, out_tvalid && out_tuser == EV_NONE,
    out_tdata[42:0] == 43'd0, "empty event carries note fields")
  `TMI_ASSERT_NOW(a_ovf_alone, out_tvalid && out_tdata[56],
    out_tuser == EV_NONE && out_tdata[42:0] == 43'd0, "overflow with an event")
  `TMI_ASSERT_NOW(a_tie_fields, out_tvalid && out_tuser == EV_TIE,
    out_tdata[42:9] == 34'd0, "tie carries note fields")

endmodule

bind turtle_melody_interpreter tmi_checker u_tmi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[sim/turtle_melody_interpreter_tb.sv]
// testbench for turtle_melody_interpreter: directed script, saturation runs and random
// symbol streams, each result word checked against a scripted value or a local melody predictor
// depends on tmi_pkg and the turtle_melody_interpreter rtl
module turtle_melody_interpreter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmi_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  note_idx;
    logic [12:0] start;
    logic [6:0]  midi;
    logic [13:0] accent;
    logic [12:0] phrase;
    logic        overflow;
  } melody_event_t;

  typedef struct packed {
    logic [1:0]    req;
    logic [6:0]    lidx;
    logic [6:0]    lnote;
    logic [7:0]    sym;
    logic          fixed;
    melody_event_t want;
  } script_row_t;

  localparam melody_event_t NO_EVENT = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // ladder_index, ladder_note, symbol
  logic [1:0]  in_tuser = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // event_index, start_step, midi_note, accent_marks,
                                // phrase_length, stack_overflow
  logic [1:0]  out_tuser;       // event_kind
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;  // ladder_length

  turtle_melody_interpreter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [7:0] lad_len;
  logic [6:0] lad_notes [128];
  int         tt_step, tt_pos, tt_oct, tt_stack_n;
  int         saved_step [STACK_DEPTH];
  int         saved_pos [STACK_DEPTH];
  int         saved_oct [STACK_DEPTH];
  bit         tie_ok;
  int         tie_note, acc_wait, notes_made, step_high;

  melody_event_t events_due [$];
  int            fail_count = 0;
  bit            idle_on = 1'b0;
  int            stall_left = 0;

  script_row_t script [27] = '{
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_NOTE, 1'b1, '{EV_NOTE, 9'd0, 13'd0, 7'd48, 14'd0, 13'd1, 1'b0}},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_TIE, 1'b1, '{EV_TIE, 9'd0, 13'd0, 7'd0, 14'd0, 13'd2, 1'b0}},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_TIE, 1'b1, '{EV_TIE, 9'd0, 13'd0, 7'd0, 14'd0, 13'd3, 1'b0}},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_REST, 1'b1, '{EV_NONE, 9'd0, 13'd0, 7'd0, 14'd0, 13'd4, 1'b0}},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_TIE, 1'b1, '{EV_NONE, 9'd0, 13'd0, 7'd0, 14'd0, 13'd5, 1'b0}},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_ACC_UP, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_ACC_UP, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_ACC_DN, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_UP, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_NOTE, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_PUSH, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_DOWN, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_DOWN, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_NOTE, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_POP, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_POP, 1'b1, '{EV_NONE, 9'd0, 13'd0, 7'd0, 14'd0, 13'd7, 1'b0}},
    '{REQ_SYMBOL, 7'd127, 7'd127, 8'hFF, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, 8'h00, 1'b0, NO_EVENT},
    '{REQ_LOAD, 7'd127, 7'd127, 8'h00, 1'b0, NO_EVENT},
    '{REQ_LOAD, 7'd1, 7'd127, 8'hFF, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_NOTE, 1'b1, '{EV_NOTE, 9'd3, 13'd6, 7'd127, 14'd0, 13'd7, 1'b0}},
    '{REQ_LOAD, 7'd2, 7'd0, 8'h00, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_UP, 1'b0, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_NOTE, 1'b1, '{EV_NOTE, 9'd4, 13'd7, 7'd0, 14'd0, 13'd8, 1'b0}},
    '{REQ_SPARE, 7'd127, 7'd127, 8'hFF, 1'b1, '{EV_NONE, 9'd0, 13'd0, 7'd0, 14'd0, 13'd8, 1'b0}},
    '{REQ_PHRASE, 7'd0, 7'd0, 8'h00, 1'b1, NO_EVENT},
    '{REQ_SYMBOL, 7'd0, 7'd0, SYM_NOTE, 1'b0, NO_EVENT}
  };

  function automatic void clear_turtle();
    tt_step = 0;
    tt_pos = 0;
    tt_oct = 0;
    tt_stack_n = 0;
    tie_ok = 1'b0;
    tie_note = 0;
    acc_wait = 0;
    notes_made = 0;
    step_high = 0;
  endfunction

  function automatic melody_event_t play_word(input logic [1:0] req, input logic [6:0] lidx,
                                              input logic [6:0] lnote, input logic [7:0] sym);
    melody_event_t ev;
    int span, p, m;
    ev = '0;
    span = (lad_len > 8'd128) ? 128 : int'(lad_len);
    p = tt_pos;
    if (span > 0 && p >= span) p = span - 1;
    if (req == REQ_LOAD) begin
      lad_notes[lidx] = lnote;
    end else if (req == REQ_PHRASE) begin
      clear_turtle();
    end else if (req == REQ_SYMBOL) begin
      case (sym)
        SYM_NOTE: begin
          tie_ok = 1'b0;
          if (span > 0) begin
            m = int'(lad_notes[p]) + 12 * tt_oct;
            if (m >= 0 && m <= 127 && notes_made < MAX_NOTES) begin
              ev.kind = EV_NOTE;
              ev.note_idx = 9'(notes_made);
              ev.start = 13'(tt_step);
              ev.midi = 7'(m);
              ev.accent = 14'(acc_wait);
              tie_note = notes_made;
              tie_ok = 1'b1;
              notes_made++;
            end
          end
          acc_wait = 0;
          if (tt_step < MAX_STEPS) tt_step++;
        end
        SYM_REST: begin
          tie_ok = 1'b0;
          if (tt_step < MAX_STEPS) tt_step++;
        end
        SYM_TIE: begin
          if (tie_ok) begin
            ev.kind = EV_TIE;
            ev.note_idx = 9'(tie_note);
          end
          if (tt_step < MAX_STEPS) tt_step++;
        end
        SYM_ACC_UP: if (acc_wait < ACC_MAX) acc_wait++;
        SYM_ACC_DN: if (acc_wait > ACC_MIN) acc_wait--;
        SYM_UP: begin
          if (span > 0) begin
            if (p + 1 < span) begin
              tt_pos = p + 1;
            end else if (tt_oct < OCT_MAX) begin
              tt_pos = 0;
              tt_oct++;
            end else begin
              tt_pos = p;
            end
          end
        end
        SYM_DOWN: begin
          if (span > 0) begin
            if (p > 0) begin
              tt_pos = p - 1;
            end else if (tt_oct > OCT_MIN) begin
              tt_pos = span - 1;
              tt_oct--;
            end else begin
              tt_pos = p;
            end
          end
        end
        SYM_PUSH: begin
          tie_ok = 1'b0;
          if (tt_stack_n < STACK_DEPTH) begin
            saved_step[tt_stack_n] = tt_step;
            saved_pos[tt_stack_n] = tt_pos;
            saved_oct[tt_stack_n] = tt_oct;
            tt_stack_n++;
          end else begin
            ev.overflow = 1'b1;
          end
        end
        SYM_POP: begin
          tie_ok = 1'b0;
          if (tt_stack_n > 0) begin
            tt_stack_n--;
            tt_step = saved_step[tt_stack_n];
            tt_pos = saved_pos[tt_stack_n];
            tt_oct = saved_oct[tt_stack_n];
          end
        end
        default: ;
      endcase
      if (tt_step > step_high) step_high = tt_step;
    end
    ev.phrase = 13'(step_high);
    return ev;
  endfunction

  task automatic send_word(input logic [1:0] req, input logic [6:0] lidx,
                           input logic [6:0] lnote, input logic [7:0] sym,
                           input logic fixed, input melody_event_t want);
    melody_event_t ev;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {2'b00, sym, lnote, lidx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ev = play_word(req, lidx, lnote, sym);
    events_due.insert(events_due.size(), fixed ? want : ev);
  endtask

  task automatic send_sym(input logic [7:0] sym);
    send_word(REQ_SYMBOL, 7'($urandom), 7'($urandom), sym, 1'b0, NO_EVENT);
  endtask

  task automatic send_sym_run(input logic [7:0] sym, input int count);
    repeat (count) send_sym(sym);
  endtask

  // only while nothing is in flight
  task automatic set_ladder_len(input logic [7:0] len);
    in_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    lad_len = len;
  endtask

  task automatic flag_field(input string name, input logic [15:0] exp_v,
                            input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result side: random stall bursts while idle_on is set, else always ready
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    melody_event_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.note_idx = out_tdata[8:0];
      got.start = out_tdata[21:9];
      got.midi = out_tdata[28:22];
      got.accent = out_tdata[42:29];
      got.phrase = out_tdata[55:43];
      got.overflow = out_tdata[56];
      if (events_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none actual kind %0d data %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = events_due.pop_front();
        flag_field("event_kind", 16'(want.kind), 16'(got.kind));
        flag_field("event_index", 16'(want.note_idx), 16'(got.note_idx));
        flag_field("start_step", 16'(want.start), 16'(got.start));
        flag_field("midi_note", 16'(want.midi), 16'(got.midi));
        flag_field("accent_marks", 16'(want.accent), 16'(got.accent));
        flag_field("phrase_length", 16'(want.phrase), 16'(got.phrase));
        flag_field("stack_overflow", 16'(want.overflow), 16'(got.overflow));
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] phase_len [7];
    logic [1:0] req;
    logic [6:0] lidx, lnote;
    logic [7:0] sym;
    int         pick;

    lad_len = 8'd5;
    foreach (lad_notes[i]) lad_notes[i] = '0;
    lad_notes[0] = 7'd48;
    lad_notes[1] = 7'd50;
    lad_notes[2] = 7'd52;
    lad_notes[3] = 7'd55;
    lad_notes[4] = 7'd57;
    clear_turtle();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_ladder_len(8'd5);
    foreach (script[i]) begin
      send_word(script[i].req, script[i].lidx, script[i].lnote, script[i].sym,
                script[i].fixed, script[i].want);
    end

    // note table full
    send_word(REQ_PHRASE, 7'd0, 7'd0, 8'h00, 1'b0, NO_EVENT);
    send_word(REQ_LOAD, 7'd0, 7'd60, 8'h00, 1'b0, NO_EVENT);
    send_sym_run(SYM_NOTE, 515);
    send_sym_run(SYM_REST, 4);
    send_sym(SYM_TIE);
    send_sym(SYM_NOTE);

    // accent marks both ways
    send_word(REQ_PHRASE, 7'd0, 7'd0, 8'h00, 1'b0, NO_EVENT);
    send_sym_run(SYM_ACC_UP, 10);
    send_sym(SYM_NOTE);
    send_sym_run(SYM_ACC_DN, 10);
    send_sym(SYM_NOTE);

    // stack overflow and pop past empty
    send_sym_run(SYM_PUSH, 66);
    send_sym_run(SYM_POP, 67);

    // octave moves with a one-note ladder
    set_ladder_len(8'd1);
    send_word(REQ_PHRASE, 7'd0, 7'd0, 8'h00, 1'b0, NO_EVENT);
    send_sym_run(SYM_UP, 10);
    send_sym(SYM_NOTE);
    send_word(REQ_PHRASE, 7'd0, 7'd0, 8'h00, 1'b0, NO_EVENT);
    send_sym_run(SYM_DOWN, 10);
    send_sym(SYM_NOTE);

    // position left past the end of a shrunk ladder
    set_ladder_len(8'd128);
    send_word(REQ_PHRASE, 7'd0, 7'd0, 8'h00, 1'b0, NO_EVENT);
    send_sym_run(SYM_UP, 20);
    set_ladder_len(8'd3);
    send_sym(SYM_NOTE);
    send_sym(SYM_UP);
    send_sym(SYM_DOWN);
    send_sym(SYM_NOTE);

    phase_len[0] = 8'd0;
    phase_len[1] = 8'd1;
    phase_len[2] = 8'd255;
    phase_len[3] = 8'd128;
    phase_len[4] = 8'($urandom_range(2, 12));
    phase_len[5] = 8'($urandom_range(0, 255));
    phase_len[6] = 8'd5;
    foreach (phase_len[ph]) begin
      set_ladder_len(phase_len[ph]);
      for (int k = 0; k < 92; k++) begin
        if (k % 40 == 0) idle_on = (ph != 6) && ($urandom_range(0, 3) != 0);
        req = REQ_SYMBOL;
        lidx = 7'($urandom);
        lnote = 7'($urandom);
        sym = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          req = REQ_LOAD;
          if ($urandom_range(0, 1) == 0) lidx = 7'($urandom_range(0, 7));
          if ($urandom_range(0, 1) == 0) lnote = 7'($urandom_range(36, 84));
        end else if (pick < 8) begin
          req = REQ_PHRASE;
        end else if (pick < 9) begin
          req = REQ_SPARE;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 30) sym = SYM_NOTE;
          else if (pick < 40) sym = SYM_TIE;
          else if (pick < 47) sym = SYM_REST;
          else if (pick < 57) sym = SYM_UP;
          else if (pick < 67) sym = SYM_DOWN;
          else if (pick < 75) sym = SYM_PUSH;
          else if (pick < 83) sym = SYM_POP;
          else if (pick < 88) sym = SYM_ACC_UP;
          else if (pick < 93) sym = SYM_ACC_DN;
        end
        send_word(req, lidx, lnote, sym, 1'b0, NO_EVENT);
      end
    end

    in_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
